### rtl/pbd_pkg.sv
`timescale 1ns / 1ps
package pbd_pkg;

  // Cipher modes; the unused code decodes as pass-through
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_COMP = 2'd1,
    MODE_HIGH = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY  = 8'd1;

  // One accepted byte with the salt and mode that apply to it
  typedef struct packed {
    logic [7:0]  cipher_byte;
    logic        block_last;
    mode_t       mode;
    logic [15:0] salt;
  } pbd_item_t;

  // Compressible substitution, also the last table of high mode
  localparam logic [7:0] TAB_SUB [256] = '{
    8'h47,8'hf1,8'hb4,8'he6,8'h0b,8'h6a,8'h72,8'h48,8'h85,8'h4e,8'h9e,8'heb,8'he2,8'hf8,8'h94,8'h53,
    8'he0,8'hbb,8'ha0,8'h02,8'he8,8'h5a,8'h09,8'hab,8'hdb,8'he3,8'hba,8'hc6,8'h7c,8'hc3,8'h10,8'hdd,
    8'h39,8'h05,8'h96,8'h30,8'hf5,8'h37,8'h60,8'h82,8'h8c,8'hc9,8'h13,8'h4a,8'h6b,8'h1d,8'hf3,8'hfb,
    8'h8f,8'h26,8'h97,8'hca,8'h91,8'h17,8'h01,8'hc4,8'h32,8'h2d,8'h6e,8'h31,8'h95,8'hff,8'hd9,8'h23,
    8'hd1,8'h00,8'h5e,8'h79,8'hdc,8'h44,8'h3b,8'h1a,8'h28,8'hc5,8'h61,8'h57,8'h20,8'h90,8'h3d,8'h83,
    8'hb9,8'h43,8'hbe,8'h67,8'hd2,8'h46,8'h42,8'h76,8'hc0,8'h6d,8'h5b,8'h7e,8'hb2,8'h0f,8'h16,8'h29,
    8'h3c,8'ha9,8'h03,8'h54,8'h0d,8'hda,8'h5d,8'hdf,8'hf6,8'hb7,8'hc7,8'h62,8'hcd,8'h8d,8'h06,8'hd3,
    8'h69,8'h5c,8'h86,8'hd6,8'h14,8'hf7,8'ha5,8'h66,8'h75,8'hac,8'hb1,8'he9,8'h45,8'h21,8'h70,8'h0c,
    8'h87,8'h9f,8'h74,8'ha4,8'h22,8'h4c,8'h6f,8'hbf,8'h1f,8'h56,8'haa,8'h2e,8'hb3,8'h78,8'h33,8'h50,
    8'hb0,8'ha3,8'h92,8'hbc,8'hcf,8'h19,8'h1c,8'ha7,8'h63,8'hcb,8'h1e,8'h4d,8'h3e,8'h4b,8'h1b,8'h9b,
    8'h4f,8'he7,8'hf0,8'hee,8'had,8'h3a,8'hb5,8'h59,8'h04,8'hea,8'h40,8'h55,8'h25,8'h51,8'he5,8'h7a,
    8'h89,8'h38,8'h68,8'h52,8'h7b,8'hfc,8'h27,8'hae,8'hd7,8'hbd,8'hfa,8'h07,8'hf4,8'hcc,8'h8e,8'h5f,
    8'hef,8'h35,8'h9c,8'h84,8'h2b,8'h15,8'hd5,8'h77,8'h34,8'h49,8'hb6,8'h12,8'h0a,8'h7f,8'h71,8'h88,
    8'hfd,8'h9d,8'h18,8'h41,8'h7d,8'h93,8'hd8,8'h58,8'h2c,8'hce,8'hfe,8'h24,8'haf,8'hde,8'hb8,8'h36,
    8'hc8,8'ha1,8'h80,8'ha6,8'h99,8'h98,8'ha8,8'h2f,8'h0e,8'h81,8'h65,8'h73,8'he4,8'hc2,8'ha2,8'h8a,
    8'hd4,8'he1,8'h11,8'hd0,8'h08,8'h8b,8'h2a,8'hf2,8'hed,8'h9a,8'h64,8'h3f,8'hc1,8'h6c,8'hf9,8'hec
  };

  // First table of high mode
  localparam logic [7:0] TAB_R1 [256] = '{
    8'h41,8'h36,8'h13,8'h62,8'ha8,8'h21,8'h6e,8'hbb,8'hf4,8'h16,8'hcc,8'h04,8'h7f,8'h64,8'he8,8'h5d,
    8'h1e,8'hf2,8'hcb,8'h2a,8'h74,8'hc5,8'h5e,8'h35,8'hd2,8'h95,8'h47,8'h9e,8'h96,8'h2d,8'h9a,8'h88,
    8'h4c,8'h7d,8'h84,8'h3f,8'hdb,8'hac,8'h31,8'hb6,8'h48,8'h5f,8'hf6,8'hc4,8'hd8,8'h39,8'h8b,8'he7,
    8'h23,8'h3b,8'h38,8'h8e,8'hc8,8'hc1,8'hdf,8'h25,8'hb1,8'h20,8'ha5,8'h46,8'h60,8'h4e,8'h9c,8'hfb,
    8'haa,8'hd3,8'h56,8'h51,8'h45,8'h7c,8'h55,8'h00,8'h07,8'hc9,8'h2b,8'h9d,8'h85,8'h9b,8'h09,8'ha0,
    8'h8f,8'had,8'hb3,8'h0f,8'h63,8'hab,8'h89,8'h4b,8'hd7,8'ha7,8'h15,8'h5a,8'h71,8'h66,8'h42,8'hbf,
    8'h26,8'h4a,8'h6b,8'h98,8'hfa,8'hea,8'h77,8'h53,8'hb2,8'h70,8'h05,8'h2c,8'hfd,8'h59,8'h3a,8'h86,
    8'h7e,8'hce,8'h06,8'heb,8'h82,8'h78,8'h57,8'hc7,8'h8d,8'h43,8'haf,8'hb4,8'h1c,8'hd4,8'h5b,8'hcd,
    8'he2,8'he9,8'h27,8'h4f,8'hc3,8'h08,8'h72,8'h80,8'hcf,8'hb0,8'hef,8'hf5,8'h28,8'h6d,8'hbe,8'h30,
    8'h4d,8'h34,8'h92,8'hd5,8'h0e,8'h3c,8'h22,8'h32,8'he5,8'he4,8'hf9,8'h9f,8'hc2,8'hd1,8'h0a,8'h81,
    8'h12,8'he1,8'hee,8'h91,8'h83,8'h76,8'he3,8'h97,8'he6,8'h61,8'h8a,8'h17,8'h79,8'ha4,8'hb7,8'hdc,
    8'h90,8'h7a,8'h5c,8'h8c,8'h02,8'ha6,8'hca,8'h69,8'hde,8'h50,8'h1a,8'h11,8'h93,8'hb9,8'h52,8'h87,
    8'h58,8'hfc,8'hed,8'h1d,8'h37,8'h49,8'h1b,8'h6a,8'he0,8'h29,8'h33,8'h99,8'hbd,8'h6c,8'hd9,8'h94,
    8'hf3,8'h40,8'h54,8'h6f,8'hf0,8'hc6,8'h73,8'hb8,8'hd6,8'h3e,8'h65,8'h18,8'h44,8'h1f,8'hdd,8'h67,
    8'h10,8'hf1,8'h0c,8'h19,8'hec,8'hae,8'h03,8'ha1,8'h14,8'h7b,8'ha9,8'h0b,8'hff,8'hf8,8'ha3,8'hc0,
    8'ha2,8'h01,8'hf7,8'h2e,8'hbc,8'h24,8'h68,8'h75,8'h0d,8'hfe,8'hba,8'h2f,8'hb5,8'hd0,8'hda,8'h3d
  };

  // Second table of high mode
  localparam logic [7:0] TAB_R2 [256] = '{
    8'h14,8'h53,8'h0f,8'h56,8'hb3,8'hc8,8'h7a,8'h9c,8'heb,8'h65,8'h48,8'h17,8'h16,8'h15,8'h9f,8'h02,
    8'hcc,8'h54,8'h7c,8'h83,8'h00,8'h0d,8'h0c,8'h0b,8'ha2,8'h62,8'ha8,8'h76,8'hdb,8'hd9,8'hed,8'hc7,
    8'hc5,8'ha4,8'hdc,8'hac,8'h85,8'h74,8'hd6,8'hd0,8'ha7,8'h9b,8'hae,8'h9a,8'h96,8'h71,8'h66,8'hc3,
    8'h63,8'h99,8'hb8,8'hdd,8'h73,8'h92,8'h8e,8'h84,8'h7d,8'ha5,8'h5e,8'hd1,8'h5d,8'h93,8'hb1,8'h57,
    8'h51,8'h50,8'h80,8'h89,8'h52,8'h94,8'h4f,8'h4e,8'h0a,8'h6b,8'hbc,8'h8d,8'h7f,8'h6e,8'h47,8'h46,
    8'h41,8'h40,8'h44,8'h01,8'h11,8'hcb,8'h03,8'h3f,8'hf7,8'hf4,8'he1,8'ha9,8'h8f,8'h3c,8'h3a,8'hf9,
    8'hfb,8'hf0,8'h19,8'h30,8'h82,8'h09,8'h2e,8'hc9,8'h9d,8'ha0,8'h86,8'h49,8'hee,8'h6f,8'h4d,8'h6d,
    8'hc4,8'h2d,8'h81,8'h34,8'h25,8'h87,8'h1b,8'h88,8'haa,8'hfc,8'h06,8'ha1,8'h12,8'h38,8'hfd,8'h4c,
    8'h42,8'h72,8'h64,8'h13,8'h37,8'h24,8'h6a,8'h75,8'h77,8'h43,8'hff,8'he6,8'hb4,8'h4b,8'h36,8'h5c,
    8'he4,8'hd8,8'h35,8'h3d,8'h45,8'hb9,8'h2c,8'hec,8'hb7,8'h31,8'h2b,8'h29,8'h07,8'h68,8'ha3,8'h0e,
    8'h69,8'h7b,8'h18,8'h9e,8'h21,8'h39,8'hbe,8'h28,8'h1a,8'h5b,8'h78,8'hf5,8'h23,8'hca,8'h2a,8'hb0,
    8'haf,8'h3e,8'hfe,8'h04,8'h8c,8'he7,8'he5,8'h98,8'h32,8'h95,8'hd3,8'hf6,8'h4a,8'he8,8'ha6,8'hea,
    8'he9,8'hf3,8'hd5,8'h2f,8'h70,8'h20,8'hf2,8'h1f,8'h05,8'h67,8'had,8'h55,8'h10,8'hce,8'hcd,8'he3,
    8'h27,8'h3b,8'hda,8'hba,8'hd7,8'hc2,8'h26,8'hd4,8'h91,8'h1d,8'hd2,8'h1c,8'h22,8'h33,8'hf8,8'hfa,
    8'hf1,8'h5a,8'hef,8'hcf,8'h90,8'hb6,8'h8b,8'hb5,8'hbd,8'hc0,8'hbf,8'h08,8'h97,8'h1e,8'h6c,8'he2,
    8'h61,8'he0,8'hc6,8'hc1,8'h59,8'hab,8'hbb,8'h58,8'hde,8'h5f,8'hdf,8'h60,8'h79,8'h7e,8'hb2,8'h8a
  };

endpackage

### rtl/pbd_salt.sv
`timescale 1ns / 1ps
module pbd_salt
  import pbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        last,
  input  logic [31:0] key,
  output logic [15:0] salt_cur
);

  logic [15:0] salt;
  logic        at_start;

  // Reload the salt from the folded key at each block start
  always_comb begin
    salt_cur = at_start ? (key[31:16] ^ key[15:0]) : salt;
  end

  // Advance the salt on every transfer and track block boundaries
  always_ff @(posedge clk) begin
    if (rst) begin
      salt     <= 16'd0;
      at_start <= 1'b1;
    end else if (fire) begin
      salt     <= salt_cur + 16'd1;
      at_start <= last;
    end
  end

endmodule

### rtl/pbd_pipe.sv
`timescale 1ns / 1ps
module pbd_pipe
  import pbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  pbd_item_t  item,
  output logic       load1,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] plain_byte,
  output logic       plain_last
);

  logic       v1, v2, v3, v4;
  logic       load2, load3, load4;

  logic [7:0] c1, c2, c3;
  logic       last1, last2, last3;
  mode_t      mode1, mode2, mode3;
  logic [7:0] lo1, lo2, lo3;
  logic [7:0] hi1, hi2;

  logic [7:0] r1_q, r2_q, sub_q;
  logic [7:0] addr1, addr2, addr3;
  logic [7:0] out_byte;

  // A stage loads when it is empty or its contents move on
  always_comb begin
    load4 = !v4 || !out_stall;
    load3 = !v3 || load4;
    load2 = !v2 || load3;
    load1 = !v1 || load2;
  end

  // Table addresses, all mod 256
  always_comb begin
    addr1 = item.cipher_byte + item.salt[7:0];
    addr2 = r1_q + hi1;
    addr3 = (mode2 == MODE_COMP) ? c2 : (r2_q - hi2);
  end

  // Final offset and mode select
  always_comb begin
    case (mode3)
      MODE_HIGH: out_byte = sub_q - lo3;
      MODE_COMP: out_byte = sub_q;
      default:   out_byte = c3;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (load1) v1 <= fire;
      if (load2) v2 <= v1;
      if (load3) v3 <= v2;
      if (load4) v4 <= v3;
    end
  end

  // Stage 1: first table read
  always_ff @(posedge clk) begin
    if (load1) begin
      r1_q  <= TAB_R1[addr1];
      c1    <= item.cipher_byte;
      last1 <= item.block_last;
      mode1 <= item.mode;
      lo1   <= item.salt[7:0];
      hi1   <= item.salt[15:8];
    end
  end

  // Stage 2: second table read
  always_ff @(posedge clk) begin
    if (load2) begin
      r2_q  <= TAB_R2[addr2];
      c2    <= c1;
      last2 <= last1;
      mode2 <= mode1;
      lo2   <= lo1;
      hi2   <= hi1;
    end
  end

  // Stage 3: substitution table read
  always_ff @(posedge clk) begin
    if (load3) begin
      sub_q <= TAB_SUB[addr3];
      c3    <= c2;
      last3 <= last2;
      mode3 <= mode2;
      lo3   <= lo2;
    end
  end

  // Stage 4: output register, held while stalled
  always_ff @(posedge clk) begin
    if (load4) begin
      plain_byte <= out_byte;
      plain_last <= last3;
    end
  end

  assign out_valid = v4;

endmodule

### rtl/pst_block_byte_decrypt_top.sv
`timescale 1ns / 1ps
// Byte-serial block decoder with pass-through, compressible and high modes.
// Input channel: in_valid / in_stall with cipher_byte and block_last; one
//   byte transfers at each edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with plain_byte and plain_last; one
//   decoded byte per input byte, in order.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
//   is cipher_mode, index 1 is block_key, others are ignored. cfg_ready is
//   always high. Write only while no byte is in flight.
// Pipeline: the first table read registers at the input transfer edge, then
//   two more table reads and the output register follow. Throughput: one
//   byte per cycle while out_stall is low; the pipeline holds four bytes.
// Stall: a stalled output holds its byte; upstream stages keep filling
//   bubbles and in_stall rises only once all four stages are full.
// Reset: clears the pipeline, sets mode to pass-through and key to zero, and
//   makes the next byte start a block. in_stall is high during reset.
module pst_block_byte_decrypt_top
  import pbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           cipher_byte,
  input  logic                 block_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           plain_byte,
  output logic                 plain_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  mode_t       cipher_mode;
  logic [31:0] block_key;
  logic        load1;
  logic        fire;
  logic [15:0] salt_cur;
  pbd_item_t   item;

  assign cfg_ready = 1'b1;
  assign in_stall  = rst || !load1;
  assign fire      = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_mode <= MODE_NONE;
      block_key   <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE: cipher_mode <= mode_t'(cfg_data[1:0]);
        REG_KEY:  block_key   <= cfg_data;
        default:  ;
      endcase
    end
  end

  pbd_salt u_salt (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .last     (block_last),
    .key      (block_key),
    .salt_cur (salt_cur)
  );

  // Bundle the byte with its salt and mode
  always_comb begin
    item.cipher_byte = cipher_byte;
    item.block_last  = block_last;
    item.mode        = cipher_mode;
    item.salt        = salt_cur;
  end

  pbd_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (item),
    .load1      (load1),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .plain_byte (plain_byte),
    .plain_last (plain_last)
  );

endmodule

### rtl/pbd_checker.sv
`timescale 1ns / 1ps
module pbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] plain_byte,
  input logic       plain_last,
  input logic       cfg_ready
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Input backs up only behind a full pipeline
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // An output transfer frees room for an input transfer
  a_out_frees_in: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |-> !in_stall)
    else $error("input stalled during output transfer");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(plain_byte) && $stable(plain_last)))
    else $error("stalled result changed");

  // Configuration port never backs up
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind pst_block_byte_decrypt_top pbd_checker u_pbd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .plain_byte (plain_byte),
  .plain_last (plain_last),
  .cfg_ready  (cfg_ready)
);
